// ===== design/ioq_pkg.sv =====
// ----------------------------------------------------------------------------
// ioq_pkg: shared types and constants of the iteration ordered queue
// Field widths, command and status codes, controller to datapath commands.
// ----------------------------------------------------------------------------
package ioq_pkg;

  // field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 5;

  // default number of entries
  localparam int unsigned DEPTH_DEFAULT = 16;

  // request codes, the fourth code is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;  // capture the request on an input transfer
    logic exec;     // carry out the captured request and load the result
  } ioq_cmd_t;

endpackage

// ===== design/ioq_if.sv =====
// ----------------------------------------------------------------------------
// ioq_if: request and result channels of the iteration ordered queue
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------

// request channel
interface ioq_in_if;
  logic                      valid;
  logic                      ready;
  logic [ioq_pkg::CMD_W-1:0] cmd;
  logic [ioq_pkg::KEY_W-1:0] key;
  logic [ioq_pkg::PAY_W-1:0] payload;

  modport source (output valid, cmd, key, payload, input ready);
  modport sink   (input valid, cmd, key, payload, output ready);
endinterface

// result channel
interface ioq_out_if;
  logic                      valid;
  logic                      ready;
  logic [ioq_pkg::ST_W-1:0]  status;
  logic [ioq_pkg::KEY_W-1:0] key_out;
  logic [ioq_pkg::PAY_W-1:0] payload_out;
  logic [ioq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, status, key_out, payload_out, occupancy, input ready);
  modport sink   (input valid, status, key_out, payload_out, occupancy, output ready);
endinterface

// ===== design/iteration_ordered_queue_unit.sv =====
// ----------------------------------------------------------------------------
// iteration_ordered_queue_unit: queue kept sorted by ascending key
// Put inserts before the first entry with a key not smaller, get removes
// the head, peek reads it; each request returns one result.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries requests (cmd, key, payload); out_o carries one result per
//   request (status, key_out, payload_out, occupancy after the request).
//   Both are valid/ready channels; a transfer happens when both are high.
//   A request is captured in the idle state and carried out in the
//   execute state once the result register is free, which loads its result.
//   No new request is taken before the last one is carried out; one is
//   taken while the previous result still waits in the output register.
//   The cell row compares every cell with the new key in parallel and
//   shifts at once, so the time per request does not depend on DEPTH.
//   Reset empties the queue at once; no clearing pass is needed.
//   When the receiver stalls, the result holds and a request already taken
//   waits in the execute state until the result register is drained; no
//   further request is taken meanwhile.
//   A put into a full queue is dropped with status full; get or peek on an
//   empty queue returns status empty with zero key and payload.
// ----------------------------------------------------------------------------
module iteration_ordered_queue_unit #(
  parameter int unsigned DEPTH = ioq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ioq_in_if.sink    in_i,
  ioq_out_if.source out_o
);
  import ioq_pkg::*;

  ioq_cmd_t cmd;

  // sequencing controller
  ioq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // cell row and result register
  ioq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_cmd_i     (in_i.cmd),
    .req_key_i     (in_i.key),
    .req_payload_i (in_i.payload),
    .status_o      (out_o.status),
    .key_out_o     (out_o.key_out),
    .payload_out_o (out_o.payload_out),
    .occupancy_o   (out_o.occupancy)
  );

endmodule

// ===== design/ioq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ioq_ctrl: sequencing controller of the iteration ordered queue
// Takes one request, runs it once the result register is free, and
// holds the result valid until the receiver takes it.
// ----------------------------------------------------------------------------
module ioq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ioq_pkg::ioq_cmd_t cmd_o
);
  import ioq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_free;

  // result register free now or drained at this edge
  assign res_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.load_in = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/ioq_datapath.sv =====
// ----------------------------------------------------------------------------
// ioq_datapath: sorted cell row and result register
// Each cell compares its key with the new key in parallel; a put shifts
// the cells from the insertion point one place up, a get shifts all down.
// ----------------------------------------------------------------------------
module ioq_datapath #(
  parameter int unsigned DEPTH = ioq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ioq_pkg::ioq_cmd_t         cmd_i,
  input  logic [ioq_pkg::CMD_W-1:0] req_cmd_i,
  input  logic [ioq_pkg::KEY_W-1:0] req_key_i,
  input  logic [ioq_pkg::PAY_W-1:0] req_payload_i,
  output logic [ioq_pkg::ST_W-1:0]  status_o,
  output logic [ioq_pkg::KEY_W-1:0] key_out_o,
  output logic [ioq_pkg::PAY_W-1:0] payload_out_o,
  output logic [ioq_pkg::OCC_W-1:0] occupancy_o
);
  import ioq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // captured request
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;

  // cell row and fill count
  logic [KEY_W-1:0] key_cells_q [DEPTH];
  logic [PAY_W-1:0] pay_cells_q [DEPTH];
  logic [CW-1:0]    count_q;

  // result register
  logic [ST_W-1:0]  st_q, st_d;
  logic [KEY_W-1:0] ko_q, ko_d;
  logic [PAY_W-1:0] po_q, po_d;

  logic             full, empty, shift_in, shift_out;
  logic [DEPTH-1:0] lt;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign shift_in  = cmd_i.exec && (cmd_q == CMD_PUT) && !full;
  assign shift_out = cmd_i.exec && (cmd_q == CMD_GET) && !empty;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= req_cmd_i;
      key_q <= req_key_i;
      pay_q <= req_payload_i;
    end
  end

  // per-cell compare and shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned P = (g == 0) ? 0 : g - 1;
    localparam int unsigned N = (g == DEPTH - 1) ? g : g + 1;

    logic [KEY_W-1:0] kd;
    logic [PAY_W-1:0] pd;

    // valid cell holding a smaller key stays in place on a put
    assign lt[g] = (CW'(g) < count_q) && (key_cells_q[g] < key_q);

    always_comb begin
      kd = key_cells_q[g];
      pd = pay_cells_q[g];
      if (shift_in && !lt[g]) begin
        if (g == 0 || lt[P]) begin
          kd = key_q;
          pd = pay_q;
        end else begin
          kd = key_cells_q[P];
          pd = pay_cells_q[P];
        end
      end else if (shift_out) begin
        kd = key_cells_q[N];
        pd = pay_cells_q[N];
      end
    end

    always_ff @(posedge clk_i) begin
      key_cells_q[g] <= kd;
      pay_cells_q[g] <= pd;
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (shift_in) begin
      count_q <= count_q + CW'(1);
    end else if (shift_out) begin
      count_q <= count_q - CW'(1);
    end
  end

  // result next value
  always_comb begin
    st_d = ST_OK;
    ko_d = '0;
    po_d = '0;
    case (cmd_q)
      CMD_PUT: begin
        if (full) begin
          st_d = ST_FULL;
        end
      end
      CMD_GET, CMD_PEEK: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          ko_d = key_cells_q[0];
          po_d = pay_cells_q[0];
        end
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      st_q <= st_d;
      ko_q <= ko_d;
      po_q <= po_d;
    end
  end

  assign status_o      = st_q;
  assign key_out_o     = ko_q;
  assign payload_out_o = po_q;
  assign occupancy_o   = OCC_W'(count_q);

endmodule

// ===== design/ioq_checker.sv =====
// ----------------------------------------------------------------------------
// ioq_checker: port-level checks of the iteration ordered queue
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ioq_checker #(
  parameter int unsigned DEPTH = ioq_pkg::DEPTH_DEFAULT
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [ioq_pkg::ST_W-1:0]  status_i,
  input logic [ioq_pkg::KEY_W-1:0] key_out_i,
  input logic [ioq_pkg::PAY_W-1:0] payload_out_i,
  input logic [ioq_pkg::OCC_W-1:0] occupancy_i
);
  import ioq_pkg::*;

  // one request at a time: ready drops after a request transfer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in flight");

  // a refused put reports a full queue
  a_full_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> (occupancy_i == OCC_W'(DEPTH)))
    else $error("full status with occupancy below depth");

  // an empty result carries no entry and zero occupancy
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |->
      (occupancy_i == '0) && (key_out_i == '0) && (payload_out_i == '0))
    else $error("empty status with entry data or nonzero occupancy");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(key_out_i) && $stable(payload_out_i) && $stable(occupancy_i))
    else $error("stalled result changed");

endmodule

bind iteration_ordered_queue_unit ioq_checker #(
  .DEPTH (DEPTH)
) u_ioq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .key_out_i     (out_o.key_out),
  .payload_out_i (out_o.payload_out),
  .occupancy_i   (out_o.occupancy)
);
